// ===== hw/rtl/gbl_pkg.sv =====
// Shared constants, codes and command/status types of the grid bucket list engine.
package gbl_pkg;

  localparam int POOL_NODES = 1024;
  localparam int NODE_W     = 10;
  localparam int LINK_W     = 11;
  localparam int COUNT_W    = 11;
  localparam int TILE_COUNT = 4096;
  localparam int TILE_W     = 12;
  localparam int ID_W       = 16;
  localparam int SIDE_W     = 5;
  localparam int POS_W      = 4;
  localparam int MAX_SIDE   = 16;
  localparam int ACC_W      = 8;
  localparam int CFG_IDX_W  = 2;

  localparam logic [LINK_W-1:0] NO_LINK = LINK_W'(POOL_NODES);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_DEPTH  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_REPLACE = 2'd2,
    CMD_UNUSED  = 2'd3
  } op_code_t;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_NOT_FOUND    = 2'd1,
    ST_POOL_FULL    = 2'd2,
    ST_OUT_OF_GRID  = 2'd3
  } status_t;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_CALC_ACC,
    OP_CALC_TILE,
    OP_READ_HEAD,
    OP_ADD_LINK,
    OP_ADD_TERM,
    OP_WALK_INIT,
    OP_WALK_READ,
    OP_WALK_CHECK,
    OP_REPLACE,
    OP_RM_READ,
    OP_RM_LINK,
    OP_RM_READ_LAST,
    OP_RM_COPY,
    OP_RM_FIX,
    OP_RM_COMMIT
  } dp_op_t;

  typedef struct packed {
    logic    latch;
    dp_op_t  op;
    logic    res_load;
    status_t res_status;
  } dp_cmd_t;

  typedef struct packed {
    logic     range_bad;
    op_code_t cmd;
    logic     pool_full;
    logic     walk_more;
    logic     hit;
    logic     k_is_last;
    logic     clear_last;
  } dp_sts_t;

  typedef enum logic [16:0] {
    S_CLEAR     = 17'd1 << 0,
    S_IDLE      = 17'd1 << 1,
    S_CHECK     = 17'd1 << 2,
    S_TILE      = 17'd1 << 3,
    S_HEAD      = 17'd1 << 4,
    S_BRANCH    = 17'd1 << 5,
    S_ADD_TERM  = 17'd1 << 6,
    S_WALK_RD   = 17'd1 << 7,
    S_WALK_CMP  = 17'd1 << 8,
    S_REPL      = 17'd1 << 9,
    S_RM_RD     = 17'd1 << 10,
    S_RM_LINK   = 17'd1 << 11,
    S_RM_LRD    = 17'd1 << 12,
    S_RM_COPY   = 17'd1 << 13,
    S_RM_FIX    = 17'd1 << 14,
    S_RM_COMMIT = 17'd1 << 15,
    S_RESULT    = 17'd1 << 16
  } state_t;

endpackage

// ===== hw/rtl/gbl_in_if.sv =====
// Input channel: command word with tile coordinates and ids.
interface gbl_in_if;
  import gbl_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       cmd;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic [POS_W-1:0] pos_z;
  logic [ID_W-1:0]  item_id;
  logic [ID_W-1:0]  new_id;
  modport source (output valid, cmd, pos_x, pos_y, pos_z, item_id, new_id, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, pos_z, item_id, new_id, output ready);
endinterface

// ===== hw/rtl/gbl_out_if.sv =====
// Result channel: status, pool slot and node count.
interface gbl_out_if;
  import gbl_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [NODE_W-1:0]  slot;
  logic [COUNT_W-1:0] count;
  modport source (output valid, status, slot, count, input ready);
  modport sink (input valid, status, slot, count, output ready);
endinterface

// ===== hw/rtl/gbl_cfg_if.sv =====
// Configuration write channel: register index and write data.
interface gbl_cfg_if;
  import gbl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [SIDE_W-1:0]    data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface

// ===== hw/rtl/gbl_ctrl.sv =====
// Controller state machine: sequences the datapath through each command.
module gbl_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  gbl_pkg::dp_sts_t sts,
  output gbl_pkg::dp_cmd_t cmd
);
  import gbl_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    load;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign load      = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  // pick next state and the datapath operation of this cycle
  always_comb begin
    state_nxt      = state_r;
    res_nxt        = res_r;
    cmd.latch      = 1'b0;
    cmd.op         = OP_NOP;
    cmd.res_load   = load;
    cmd.res_status = res_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.op = OP_CALC_ACC;
        if (sts.range_bad) begin
          res_nxt   = ST_OUT_OF_GRID;
          state_nxt = S_RESULT;
        end else if (sts.cmd == CMD_UNUSED) begin
          res_nxt   = ST_NOT_FOUND;
          state_nxt = S_RESULT;
        end else begin
          state_nxt = S_TILE;
        end
      end
      S_TILE: begin
        cmd.op    = OP_CALC_TILE;
        state_nxt = S_HEAD;
      end
      S_HEAD: begin
        cmd.op    = OP_READ_HEAD;
        state_nxt = S_BRANCH;
      end
      S_BRANCH: begin
        if (sts.cmd == CMD_ADD) begin
          if (sts.pool_full) begin
            res_nxt   = ST_POOL_FULL;
            state_nxt = S_RESULT;
          end else begin
            cmd.op    = OP_ADD_LINK;
            state_nxt = S_ADD_TERM;
          end
        end else begin
          cmd.op    = OP_WALK_INIT;
          state_nxt = S_WALK_RD;
        end
      end
      S_ADD_TERM: begin
        cmd.op    = OP_ADD_TERM;
        res_nxt   = ST_DONE;
        state_nxt = S_RESULT;
      end
      S_WALK_RD: begin
        if (sts.walk_more) begin
          cmd.op    = OP_WALK_READ;
          state_nxt = S_WALK_CMP;
        end else begin
          res_nxt   = ST_NOT_FOUND;
          state_nxt = S_RESULT;
        end
      end
      S_WALK_CMP: begin
        cmd.op = OP_WALK_CHECK;
        if (!sts.hit) state_nxt = S_WALK_RD;
        else if (sts.cmd == CMD_REMOVE) state_nxt = S_RM_RD;
        else state_nxt = S_REPL;
      end
      S_REPL: begin
        cmd.op    = OP_REPLACE;
        res_nxt   = ST_DONE;
        state_nxt = S_RESULT;
      end
      S_RM_RD: begin
        cmd.op    = OP_RM_READ;
        state_nxt = S_RM_LINK;
      end
      S_RM_LINK: begin
        cmd.op    = OP_RM_LINK;
        state_nxt = sts.k_is_last ? S_RM_COMMIT : S_RM_LRD;
      end
      S_RM_LRD: begin
        cmd.op    = OP_RM_READ_LAST;
        state_nxt = S_RM_COPY;
      end
      S_RM_COPY: begin
        cmd.op    = OP_RM_COPY;
        state_nxt = S_RM_FIX;
      end
      S_RM_FIX: begin
        cmd.op    = OP_RM_FIX;
        state_nxt = S_RM_COMMIT;
      end
      S_RM_COMMIT: begin
        cmd.op    = OP_RM_COMMIT;
        res_nxt   = ST_DONE;
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // hold the result word until taken
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      res_r       <= ST_DONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/gbl_dpath.sv =====
// Datapath: tile and node memories, walk pointer, count and result registers.
module gbl_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gbl_pkg::dp_cmd_t              cmd,
  output gbl_pkg::dp_sts_t              sts,
  input  logic [1:0]                    in_cmd,
  input  logic [gbl_pkg::POS_W-1:0]     in_pos_x,
  input  logic [gbl_pkg::POS_W-1:0]     in_pos_y,
  input  logic [gbl_pkg::POS_W-1:0]     in_pos_z,
  input  logic [gbl_pkg::ID_W-1:0]      in_item_id,
  input  logic [gbl_pkg::ID_W-1:0]      in_new_id,
  input  logic                          cfg_we,
  input  logic [gbl_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [gbl_pkg::SIDE_W-1:0]    cfg_data,
  output logic [1:0]                    out_status,
  output logic [gbl_pkg::NODE_W-1:0]    out_slot,
  output logic [gbl_pkg::COUNT_W-1:0]   out_count
);
  import gbl_pkg::*;

  // memories
  logic [LINK_W-1:0] head_mem  [TILE_COUNT];
  logic [NODE_W-1:0] tail_mem  [TILE_COUNT];
  logic [ID_W-1:0]   value_mem [POOL_NODES];
  logic [LINK_W-1:0] next_mem  [POOL_NODES];
  logic [LINK_W-1:0] prev_mem  [POOL_NODES];
  logic [TILE_W-1:0] tile_mem  [POOL_NODES];

  // control registers
  logic [SIDE_W-1:0]  w_r, h_r, d_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [TILE_W-1:0]  clr_r;

  // item registers
  op_code_t           op_r, op_nxt;
  logic [POS_W-1:0]   x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic [ID_W-1:0]    id_r, nid_r, id_nxt, nid_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [TILE_W-1:0]  tile_r, tile_nxt;
  logic [LINK_W-1:0]  p_r, p_nxt, k_r, k_nxt;
  logic [COUNT_W-1:0] steps_r, steps_nxt;

  // memory read registers
  logic [LINK_W-1:0]  head_q_r;
  logic [NODE_W-1:0]  tail_q_r;
  logic [ID_W-1:0]    val_q_r;
  logic [LINK_W-1:0]  next_q_r, prev_q_r;
  logic [TILE_W-1:0]  tile_q_r;

  // result registers
  logic [1:0]         res_status_r, res_status_nxt;
  logic [NODE_W-1:0]  res_slot_r, res_slot_nxt;
  logic [COUNT_W-1:0] res_count_r, res_count_nxt;

  logic [NODE_W-1:0]  last;
  logic               head_ok, prev_ok, next_ok;
  logic               node_re, ht_re;
  logic [NODE_W-1:0]  node_ra;

  logic                 head_we, tail_we, value_we, next_we, prev_we, tile_we;
  logic [TILE_W-1:0]    head_wa, tail_wa;
  logic [LINK_W-1:0]    head_wd, next_wd, prev_wd;
  logic [NODE_W-1:0]    tail_wd, value_wa, next_wa, prev_wa, tile_wa;
  logic [ID_W-1:0]      value_wd;
  logic [TILE_W-1:0]    tile_wd;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
  endfunction

  assign last    = NODE_W'(count_r - COUNT_W'(1));
  assign head_ok = (head_q_r < count_r);
  assign prev_ok = (prev_q_r < count_r);
  assign next_ok = (next_q_r < count_r);

  // status toward the controller
  always_comb begin
    sts.range_bad  = (SIDE_W'(x_r) >= w_r) || (SIDE_W'(y_r) >= h_r) ||
                     (SIDE_W'(z_r) >= d_r);
    sts.cmd        = op_r;
    sts.pool_full  = (count_r >= COUNT_W'(POOL_NODES));
    sts.walk_more  = (steps_r < count_r) && (p_r < count_r);
    sts.hit        = (val_q_r == id_r);
    sts.k_is_last  = (k_r == LINK_W'(count_r - COUNT_W'(1)));
    sts.clear_last = (clr_r == TILE_W'(TILE_COUNT - 1));
  end

  // advance item registers
  always_comb begin
    op_nxt    = op_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    id_nxt    = id_r;
    nid_nxt   = nid_r;
    acc_nxt   = acc_r;
    tile_nxt  = tile_r;
    p_nxt     = p_r;
    k_nxt     = k_r;
    steps_nxt = steps_r;
    count_nxt = count_r;
    if (cmd.latch) begin
      op_nxt  = op_code_t'(in_cmd);
      x_nxt   = in_pos_x;
      y_nxt   = in_pos_y;
      z_nxt   = in_pos_z;
      id_nxt  = in_item_id;
      nid_nxt = in_new_id;
    end
    unique case (cmd.op)
      OP_CALC_ACC:   acc_nxt = ACC_W'(ACC_W'(y_r) * ACC_W'(d_r) + ACC_W'(z_r));
      OP_CALC_TILE:  tile_nxt = TILE_W'(TILE_W'(acc_r) * TILE_W'(w_r) + TILE_W'(x_r));
      OP_ADD_LINK:   k_nxt = LINK_W'(count_r);
      OP_ADD_TERM:   count_nxt = count_r + COUNT_W'(1);
      OP_WALK_INIT: begin
        p_nxt     = head_q_r;
        steps_nxt = '0;
      end
      OP_WALK_CHECK: begin
        if (sts.hit) begin
          k_nxt = p_r;
        end else begin
          p_nxt     = next_q_r;
          steps_nxt = steps_r + COUNT_W'(1);
        end
      end
      OP_RM_COMMIT:  count_nxt = count_r - COUNT_W'(1);
      default: ;
    endcase
  end

  // load the result word
  always_comb begin
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_count_nxt  = res_count_r;
    if (cmd.res_load) begin
      res_status_nxt = cmd.res_status;
      res_slot_nxt   = (cmd.res_status == ST_DONE) ? k_r[NODE_W-1:0] : '0;
      res_count_nxt  = count_r;
    end
  end

  assign out_status = res_status_r;
  assign out_slot   = res_slot_r;
  assign out_count  = res_count_r;

  // memory read controls
  assign ht_re   = (cmd.op == OP_READ_HEAD);
  assign node_re = (cmd.op == OP_WALK_READ) || (cmd.op == OP_RM_READ) ||
                   (cmd.op == OP_RM_READ_LAST);
  assign node_ra = (cmd.op == OP_RM_READ_LAST) ? last : p_r[NODE_W-1:0];

  // memory write ports
  always_comb begin
    head_we  = 1'b0;  head_wa  = tile_r;           head_wd  = NO_LINK;
    tail_we  = 1'b0;  tail_wa  = tile_r;           tail_wd  = count_r[NODE_W-1:0];
    value_we = 1'b0;  value_wa = count_r[NODE_W-1:0]; value_wd = id_r;
    next_we  = 1'b0;  next_wa  = count_r[NODE_W-1:0]; next_wd  = NO_LINK;
    prev_we  = 1'b0;  prev_wa  = count_r[NODE_W-1:0]; prev_wd  = NO_LINK;
    tile_we  = 1'b0;  tile_wa  = count_r[NODE_W-1:0]; tile_wd  = tile_r;
    unique case (cmd.op)
      OP_CLEAR: begin
        head_we = 1'b1;
        head_wa = clr_r;
        head_wd = NO_LINK;
      end
      OP_ADD_LINK: begin
        value_we = 1'b1;
        tile_we  = 1'b1;
        prev_we  = 1'b1;
        prev_wd  = head_ok ? LINK_W'(tail_q_r) : NO_LINK;
        tail_we  = 1'b1;
        if (head_ok) begin
          next_we = 1'b1;
          next_wa = tail_q_r;
          next_wd = LINK_W'(count_r);
        end else begin
          head_we = 1'b1;
          head_wd = LINK_W'(count_r);
        end
      end
      OP_ADD_TERM: begin
        next_we = 1'b1;
        next_wd = NO_LINK;
      end
      OP_REPLACE: begin
        value_we = 1'b1;
        value_wa = k_r[NODE_W-1:0];
        value_wd = nid_r;
      end
      OP_RM_LINK: begin
        // bridge the neighbors of the removed node
        if (prev_ok) begin
          next_we = 1'b1;
          next_wa = prev_q_r[NODE_W-1:0];
          next_wd = next_q_r;
        end else begin
          head_we = 1'b1;
          head_wa = tile_q_r;
          head_wd = next_q_r;
        end
        if (next_ok) begin
          prev_we = 1'b1;
          prev_wa = next_q_r[NODE_W-1:0];
          prev_wd = prev_q_r;
        end else begin
          tail_we = 1'b1;
          tail_wa = tile_q_r;
          tail_wd = prev_q_r[NODE_W-1:0];
        end
      end
      OP_RM_COPY: begin
        // move the last pool node into the hole
        value_we = 1'b1;  value_wa = k_r[NODE_W-1:0]; value_wd = val_q_r;
        next_we  = 1'b1;  next_wa  = k_r[NODE_W-1:0]; next_wd  = next_q_r;
        prev_we  = 1'b1;  prev_wa  = k_r[NODE_W-1:0]; prev_wd  = prev_q_r;
        tile_we  = 1'b1;  tile_wa  = k_r[NODE_W-1:0]; tile_wd  = tile_q_r;
      end
      OP_RM_FIX: begin
        // point the moved node's neighbors at its new place
        if (prev_ok) begin
          next_we = 1'b1;
          next_wa = prev_q_r[NODE_W-1:0];
          next_wd = k_r;
        end else begin
          head_we = 1'b1;
          head_wa = tile_q_r;
          head_wd = k_r;
        end
        if (next_ok) begin
          prev_we = 1'b1;
          prev_wa = next_q_r[NODE_W-1:0];
          prev_wd = k_r;
        end else begin
          tail_we = 1'b1;
          tail_wa = tile_q_r;
          tail_wd = k_r[NODE_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (ht_re) head_q_r <= head_mem[tile_r];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (ht_re) tail_q_r <= tail_mem[tile_r];
  end

  always_ff @(posedge clk) begin
    if (value_we) value_mem[value_wa] <= value_wd;
    if (node_re) val_q_r <= value_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (node_re) next_q_r <= next_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (node_re) prev_q_r <= prev_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (tile_we) tile_mem[tile_wa] <= tile_wd;
    if (node_re) tile_q_r <= tile_mem[node_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= SIDE_W'(MAX_SIDE);
      h_r     <= SIDE_W'(MAX_SIDE);
      d_r     <= SIDE_W'(MAX_SIDE);
      count_r <= '0;
      clr_r   <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.op == OP_CLEAR) clr_r <= clr_r + TILE_W'(1);
      if (cfg_we) begin
        priority case (cfg_idx)
          CFG_GRID_WIDTH:  w_r <= clamp_side(cfg_data);
          CFG_GRID_HEIGHT: h_r <= clamp_side(cfg_data);
          CFG_GRID_DEPTH:  d_r <= clamp_side(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    z_r          <= z_nxt;
    id_r         <= id_nxt;
    nid_r        <= nid_nxt;
    acc_r        <= acc_nxt;
    tile_r       <= tile_nxt;
    p_r          <= p_nxt;
    k_r          <= k_nxt;
    steps_r      <= steps_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_count_r  <= res_count_nxt;
  end

endmodule

// ===== hw/rtl/grid_bucket_list_engine.sv =====
// Top level of the grid bucket list engine: controller, datapath and channel wiring.
// A remove or replace walks the tile's list node by node; a held result stalls the next
// result. One word in flight; input ready again the cycle after the result is registered.
// Reset sets each grid side to 16, clears the count, and clears all 4096 head table
// entries, during which no input word is taken (configuration is).
module grid_bucket_list_engine (
  input logic      clk,
  input logic      rst_n,
  gbl_in_if.sink   in_ch,
  gbl_out_if.source out_ch,
  gbl_cfg_if.sink  cfg_ch
);
  import gbl_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  gbl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gbl_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_cmd     (in_ch.cmd),
    .in_pos_x   (in_ch.pos_x),
    .in_pos_y   (in_ch.pos_y),
    .in_pos_z   (in_ch.pos_z),
    .in_item_id (in_ch.item_id),
    .in_new_id  (in_ch.new_id),
    .cfg_we     (cfg_ch.valid),
    .cfg_idx    (cfg_ch.idx),
    .cfg_data   (cfg_ch.data),
    .out_status (out_ch.status),
    .out_slot   (out_ch.slot),
    .out_count  (out_ch.count)
  );

endmodule

// ===== hw/rtl/gbl_checker.sv =====
// Port-level checker of the grid bucket list engine and its bind.
module gbl_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [1:0]                   out_status,
  input logic [gbl_pkg::NODE_W-1:0]   out_slot,
  input logic [gbl_pkg::COUNT_W-1:0]  out_count
);
  import gbl_pkg::*;

  // a failed command reports slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_DONE) |-> (out_slot == '0))
    else $error("nonzero slot on failed command");

  // one word at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // pool full only with every node in use
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_POOL_FULL) |-> (out_count == COUNT_W'(POOL_NODES)))
    else $error("pool full with free nodes");

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped");

endmodule

bind grid_bucket_list_engine gbl_checker u_gbl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_slot   (out_ch.slot),
  .out_count  (out_ch.count)
);
